>>> rtl/core/sorted_range_search_unit_macros.svh
// ---------------------------------------------------------------------------
// Sorted range search unit assertion macros
// Shorthand for the concurrent checks on the unit's ports.
// ---------------------------------------------------------------------------
`ifndef SORTED_RANGE_SEARCH_UNIT_MACROS_SVH
`define SORTED_RANGE_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define SRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define SRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs during reset.
`define SRS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/srs_pkg.sv
// ---------------------------------------------------------------------------
// Sorted range search package
// Shared widths, defaults and request codes.
// ---------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int VALUE_W       = 32;
  localparam int FUNC_W        = 2;
  localparam int IDX_W         = 11;
  localparam int OUT_TDATA_W   = 24;
  localparam int OUT_TUSER_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [IDX_W-1:0] NEG_ONE_IDX = {IDX_W{1'b1}};

endpackage

`default_nettype wire

>>> rtl/core/sorted_range_search_unit.sv
// An append loads its answer into the output register when it is taken, or waits in ST_OUT
//   while the result side holds the output register. A clear answers nothing.
// A query runs two binary searches, one probe per cycle through the single memory port;
//   the unit takes no new request until the query's result has been loaded.
// Reset: rst clears the count and control state; the element memory keeps no reset
//   value and needs no clearing pass, since only entries below the count are read.
// ---------------------------------------------------------------------------
// Sorted range search unit
// Holds an ascending list of signed values in a memory and answers first and
// last occurrence queries with two binary searches over it.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_range_search_unit #(
  parameter int DEPTH = srs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Request side.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [srs_pkg::VALUE_W-1:0]     s_tdata,   // [31:0] value
  input  wire logic [srs_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
  // Result side.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [srs_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [10:0] first_index,
                                                          // [21:11] last_index, [23:22] zero
  output logic [srs_pkg::OUT_TUSER_W-1:0]      m_tuser    // [0] found, [1] overflow
);

  import srs_pkg::*;

  // Count width holds DEPTH itself; the address width only the entries.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,  // waiting for a request
    ST_LB   = 5'b00010,  // lower-bound probe outstanding
    ST_CHK  = 5'b00100,  // read of the lower-bound entry outstanding
    ST_UB   = 5'b01000,  // upper-bound probe outstanding
    ST_OUT  = 5'b10000   // result waits for the output register
  } state_t;

  // Masks an index down to the result field width.
  function automatic logic [IDX_W-1:0] to_idx(input logic [CW-1:0] i);
    logic [IDX_W+CW-1:0] w;
    w = {{IDX_W{1'b0}}, i};
    return w[IDX_W-1:0];
  endfunction

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         lo, lo_next;
  logic [CW-1:0]         hi, hi_next;
  logic [CW-1:0]         mid, mid_next;
  logic [VALUE_W-1:0]    target, target_next;
  logic                  res_found, res_found_next;
  logic                  res_ovf, res_ovf_next;
  logic [IDX_W-1:0]      res_first, res_first_next;
  logic [IDX_W-1:0]      res_last, res_last_next;

  // Element memory, one port, registered read data.
  logic [VALUE_W-1:0]    mem [DEPTH];
  logic [VALUE_W-1:0]    rdata;
  logic                  mem_we, mem_re;
  logic [CW-1:0]         mem_idx;

  logic                  accept, slot_free, out_load;
  logic                  out_found, out_ovf;
  logic [IDX_W-1:0]      out_first, out_last;

  logic                  cmp_lt, cmp_eq, cmp_le;
  logic [CW-1:0]         lb_lo, lb_hi, ub_lo, ub_hi;
  logic [CW:0]           lb_sum, ub_sum;
  logic [CW-1:0]         lb_mid, ub_mid;
  logic [CW-1:0]         mid_inc, lo_inc;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // The memory entry read last cycle against the query target.
  assign cmp_eq  = (rdata == target);
  assign cmp_lt  = $signed(rdata) < $signed(target);
  assign cmp_le  = cmp_lt || cmp_eq;
  assign mid_inc = mid + CW'(1);
  assign lo_inc  = lo + CW'(1);

  // Lower bound starts over the whole list; each probe halves the range.
  always_comb begin
    if (state == ST_LB) begin
      lb_lo = cmp_lt ? mid_inc : lo;
      lb_hi = cmp_lt ? hi : mid;
    end else begin
      lb_lo = '0;
      lb_hi = count;
    end
  end

  // Upper bound starts just past the first match.
  always_comb begin
    if (state == ST_UB) begin
      ub_lo = cmp_le ? mid_inc : lo;
      ub_hi = cmp_le ? hi : mid;
    end else begin
      ub_lo = lo_inc;
      ub_hi = count;
    end
  end

  assign lb_sum = {1'b0, lb_lo} + {1'b0, lb_hi};
  assign ub_sum = {1'b0, ub_lo} + {1'b0, ub_hi};
  assign lb_mid = lb_sum[CW:1];
  assign ub_mid = ub_sum[CW:1];

  always_comb begin
    state_next     = state;
    count_next     = count;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    target_next    = target;
    res_found_next = res_found;
    res_ovf_next   = res_ovf;
    res_first_next = res_first;
    res_last_next  = res_last;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_idx        = mid;
    out_load       = 1'b0;
    out_found      = res_found;
    out_ovf        = res_ovf;
    out_first      = res_first;
    out_last       = res_last;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            FUNC_APPEND: begin
              // A full list drops the element and flags it.
              if (count < CW'(DEPTH)) begin
                mem_we     = 1'b1;
                mem_idx    = count;
                count_next = count + CW'(1);
              end
              res_found_next = 1'b0;
              res_ovf_next   = !(count < CW'(DEPTH));
              res_first_next = NEG_ONE_IDX;
              res_last_next  = NEG_ONE_IDX;
              if (slot_free) begin
                out_load  = 1'b1;
                out_found = 1'b0;
                out_ovf   = !(count < CW'(DEPTH));
                out_first = NEG_ONE_IDX;
                out_last  = NEG_ONE_IDX;
              end else begin
                state_next = ST_OUT;
              end
            end
            FUNC_QUERY: begin
              target_next    = s_tdata;
              res_ovf_next   = 1'b0;
              res_found_next = 1'b0;
              res_first_next = NEG_ONE_IDX;
              res_last_next  = NEG_ONE_IDX;
              lo_next        = lb_lo;
              hi_next        = lb_hi;
              if (lb_lo < lb_hi) begin
                mid_next   = lb_mid;
                mem_re     = 1'b1;
                mem_idx    = lb_mid;
                state_next = ST_LB;
              end else begin
                // Empty list: nothing to probe.
                state_next = ST_OUT;
              end
            end
            FUNC_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LB: begin
        lo_next = lb_lo;
        hi_next = lb_hi;
        if (lb_lo < lb_hi) begin
          mid_next = lb_mid;
          mem_re   = 1'b1;
          mem_idx  = lb_mid;
        end else if (lb_lo < count) begin
          // Fetch the lower-bound entry to see whether it is the target.
          mem_re     = 1'b1;
          mem_idx    = lb_lo;
          state_next = ST_CHK;
        end else begin
          state_next = ST_OUT;
        end
      end

      ST_CHK: begin
        if (cmp_eq) begin
          res_found_next = 1'b1;
          res_first_next = to_idx(lo);
          lo_next        = ub_lo;
          hi_next        = ub_hi;
          if (ub_lo < ub_hi) begin
            mid_next   = ub_mid;
            mem_re     = 1'b1;
            mem_idx    = ub_mid;
            state_next = ST_UB;
          end else begin
            res_last_next = to_idx(lo);
            state_next    = ST_OUT;
          end
        end else begin
          state_next = ST_OUT;
        end
      end

      ST_UB: begin
        lo_next = ub_lo;
        hi_next = ub_hi;
        if (ub_lo < ub_hi) begin
          mid_next = ub_mid;
          mem_re   = 1'b1;
          mem_idx  = ub_mid;
        end else begin
          res_last_next = to_idx(ub_lo - CW'(1));
          state_next    = ST_OUT;
        end
      end

      ST_OUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_idx[AW-1:0]] <= s_tdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Search and result registers need no reset.
  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    target    <= target_next;
    res_found <= res_found_next;
    res_ovf   <= res_ovf_next;
    res_first <= res_first_next;
    res_last  <= res_last_next;
    if (out_load) begin
      m_tdata <= {{(OUT_TDATA_W-2*IDX_W){1'b0}}, out_last, out_first};
      m_tuser <= {out_ovf, out_found};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/srs_checker.sv
// ---------------------------------------------------------------------------
// Sorted range search checker
// Port-level checks on the sorted range search unit, bound into that module.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sorted_range_search_unit_macros.svh"

module srs_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [srs_pkg::VALUE_W-1:0]     s_tdata,
  input wire logic [srs_pkg::FUNC_W-1:0]      s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [srs_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic [srs_pkg::OUT_TUSER_W-1:0] m_tuser
);

  import srs_pkg::*;

  logic clear_req;
  logic miss;
  logic s_unused;

  assign clear_req = s_tvalid && s_tready && (s_tuser == FUNC_CLEAR);
  assign miss      = m_tvalid && !m_tuser[0];
  // The request value does not bear on any check here.
  assign s_unused  = ^s_tdata;

  // Coming out of reset the unit takes requests and shows no result.
  `SRS_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, s_tready && !m_tvalid, "reset state wrong")

  // A result that is not a hit carries minus one in both indices.
  `SRS_ASSERT_IMPLY(a_miss_idx, clk, rst, miss && !s_unused || miss && s_unused, (m_tdata[IDX_W-1:0] == NEG_ONE_IDX) && (m_tdata[2*IDX_W-1:IDX_W] == NEG_ONE_IDX), "miss without minus one indices")

  // An overflowed append never reports a hit.
  `SRS_ASSERT_IMPLY(a_ovf_nohit, clk, rst, m_tvalid && m_tuser[1], !m_tuser[0], "overflow result reports a hit")

  // A clear leaves the unit ready again in the cycle after it is taken.
  `SRS_ASSERT_NEXT(a_clear_ready, clk, rst, clear_req, s_tready, "not ready after clear")

  // A stalled result holds.
  `SRS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind sorted_range_search_unit srs_checker u_srs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/sorted_range_search_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sorted range search unit testbench
// Loads ascending lists through the request stream and queries them for the
// first and last occurrence of a target. Every answer is checked against an
// in-bench binary search over a mirrored list. Results are checked in order
// while both sides idle and stall at random.
// ---------------------------------------------------------------------------

module sorted_range_search_unit_tb;
  import srs_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1500;
  // After the last answer the tail wait gives any stray extra result time to
  // show up before the verdict.
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 2000;

  // The one request code that the unit ignores.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [IDX_W-1:0] index_t;

  // Field order matches the concatenation the result monitor builds.
  typedef struct packed {
    logic   found;
    index_t first_index;
    index_t last_index;
    logic   overflow;
  } search_answer_t;

  // Mirrors the list contents and holds the answers still owed by the unit.
  class RangeScoreboard;
    value_t         elements[$];
    search_answer_t answers[$];
    int             errors;

    function new();
      errors = 0;
    endfunction

    // First index in [lo, hi) whose element is not below the key.
    function int lower_index(int lo, int hi, value_t key);
      int mid;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (elements[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    // First index in [lo, hi) whose element is above the key.
    function int upper_index(int lo, int hi, value_t key);
      int mid;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (elements[mid] <= key) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, value_t value);
      search_answer_t ans;
      int first;
      int last;
      ans.found       = 1'b0;
      ans.first_index = NEG_ONE_IDX;
      ans.last_index  = NEG_ONE_IDX;
      ans.overflow    = 1'b0;
      case (func)
        FUNC_APPEND: begin
          // A full list drops the element and flags it.
          if (elements.size() < LIST_DEPTH) elements.push_back(value);
          else ans.overflow = 1'b1;
          answers.push_back(ans);
        end
        FUNC_QUERY: begin
          // The hit test only looks at the lower-bound entry, which also
          // fixes the answer for lists that were not loaded in order.
          first = lower_index(0, elements.size(), value);
          if (first < elements.size() && elements[first] == value) begin
            last            = upper_index(first + 1, elements.size(), value) - 1;
            ans.found       = 1'b1;
            ans.first_index = index_t'(first);
            ans.last_index  = index_t'(last);
          end
          answers.push_back(ans);
        end
        FUNC_CLEAR: begin
          elements.delete();
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string label, int want_v, int got_v);
      if (want_v != got_v) begin
        $display("%0t: %s expected %0d got %0d", $time, label, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(search_answer_t got);
      search_answer_t want;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result found %0b first %0d last %0d overflow %0b",
                 $time, got.found, $signed(got.first_index), $signed(got.last_index),
                 got.overflow);
        errors++;
      end else begin
        want = answers.pop_front();
        compare_field("found", want.found, got.found);
        compare_field("first_index", $signed(want.first_index), $signed(got.first_index));
        compare_field("last_index", $signed(want.last_index), $signed(got.last_index));
        compare_field("overflow", want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [VALUE_W-1:0]     s_tdata  = '0;
  logic [FUNC_W-1:0]      s_tuser  = FUNC_QUERY;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  RangeScoreboard board;

  // Sender burst state and the count of requests that the unit acts on.
  int burst_left  = 0;
  int sent_items  = 0;
  // Receiver stall pattern state.
  int stall_mode  = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  sorted_range_search_unit #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #2 clk = ~clk;

  // Sends one request. Requests go out in bursts; between bursts the valid
  // line drops for a random gap, which is sometimes long enough to cover a
  // whole query. A zero gap keeps valid high so back-to-back requests occur.
  task automatic send_request(input logic [FUNC_W-1:0] func, input value_t value);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 40);
      else gap = $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    s_tuser  <= func;
    s_tdata  <= value;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_request(func, value);
    if (func != FUNC_UNUSED) sent_items++;
  endtask

  // Holds the sender off until every owed answer has come back.
  task automatic drain_pause();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.answers.size() != 0) @(posedge clk);
  endtask

  // Appends n elements in ascending order starting at base. A zero step
  // makes runs of equal values; the top of the value range saturates.
  task automatic append_sorted(input int n, input longint base, input int max_step);
    longint level;
    level = base;
    repeat (n) begin
      send_request(FUNC_APPEND, value_t'(level));
      level = level + $urandom_range(0, max_step);
      if (level > 64'sd2147483647) level = 64'sd2147483647;
    end
  endtask

  // Query targets: mostly listed values, then their neighbors, the range
  // extremes, and fully random values.
  function automatic value_t pick_target();
    int     n;
    int     r;
    value_t v;
    n = board.elements.size();
    r = $urandom_range(0, 9);
    v = value_t'($urandom());
    if (n != 0 && r < 5) begin
      v = board.elements[$urandom_range(0, n - 1)];
    end else if (n != 0 && r < 7) begin
      v = board.elements[$urandom_range(0, n - 1)];
      v = $urandom_range(0, 1) ? v + 1 : v - 1;
    end else if (r == 7) begin
      case ($urandom_range(0, 3))
        0: v = value_t'(32'h8000_0000);
        1: v = value_t'(32'h7FFF_FFFF);
        2: v = '0;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  task automatic run_queries(input int k);
    repeat (k) send_request(FUNC_QUERY, pick_target());
  endtask

  // Usually clear, then load an ascending list with random spacing, query it, and now
  // and then extend the list and query again.
  task automatic sorted_segment();
    int     n;
    int     max_step;
    longint base;
    if ($urandom_range(0, 3) != 0) send_request(FUNC_CLEAR, value_t'($urandom()));
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 150) : $urandom_range(0, 24);
    case ($urandom_range(0, 4))
      0: max_step = 0;
      1: max_step = 1;
      2: max_step = 3;
      3: max_step = 1000;
      default: max_step = 1 << 24;
    endcase
    if (board.elements.size() != 0)
      base = board.elements[board.elements.size() - 1];
    else if ($urandom_range(0, 2) == 0)
      base = longint'($urandom_range(0, 200)) - 100;
    else if ($urandom_range(0, 4) == 0)
      base = -64'sd2147483648;
    else
      base = longint'(value_t'($urandom()));
    append_sorted(n, base, max_step);
    run_queries($urandom_range(3, 20));
    if ($urandom_range(0, 2) == 0 && board.elements.size() != 0) begin
      base = board.elements[board.elements.size() - 1];
      append_sorted($urandom_range(1, 10), base, max_step);
      run_queries($urandom_range(3, 10));
    end
  endtask

  // Random codes and values, which also builds lists out of order.
  task automatic noise_segment();
    repeat ($urandom_range(10, 40)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_request(FUNC_APPEND, value_t'($urandom()));
        4, 5, 6:    send_request(FUNC_QUERY, pick_target());
        7:          send_request(FUNC_CLEAR, value_t'($urandom()));
        8:          send_request(FUNC_UNUSED, value_t'($urandom()));
        default:    send_request(FUNC_QUERY, value_t'($urandom()));
      endcase
    end
  endtask

  // Result monitor and receiver stall pattern. The stall mode changes at random
  // intervals: always ready, coin flip, mostly stalled, or periodic.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result({m_tuser[0], m_tdata[10:0], m_tdata[21:11], m_tuser[1]});
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= ((stall_left % 5) < 2);
    endcase
  end

  // Watchdog: ends the run when no request or result moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit full_done;
    full_done = 1'b0;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Query an empty list and send the unused code first.
    send_request(FUNC_QUERY, value_t'(0));
    send_request(FUNC_UNUSED, value_t'(7));
    // Both range extremes, a duplicated pair and a run of three.
    send_request(FUNC_APPEND, value_t'(32'h8000_0000));
    send_request(FUNC_APPEND, value_t'(-5));
    send_request(FUNC_APPEND, value_t'(-5));
    send_request(FUNC_APPEND, value_t'(0));
    send_request(FUNC_APPEND, value_t'(7));
    send_request(FUNC_APPEND, value_t'(7));
    send_request(FUNC_APPEND, value_t'(7));
    send_request(FUNC_APPEND, value_t'(32'h7FFF_FFFF));
    // Hits at both ends and in the runs, then misses between entries.
    send_request(FUNC_QUERY, value_t'(32'h8000_0000));
    send_request(FUNC_QUERY, value_t'(-5));
    send_request(FUNC_QUERY, value_t'(7));
    send_request(FUNC_QUERY, value_t'(32'h7FFF_FFFF));
    send_request(FUNC_QUERY, value_t'(3));
    send_request(FUNC_QUERY, value_t'(-1));
    send_request(FUNC_QUERY, value_t'(32'h7FFF_FFFE));
    // A cleared list holds nothing, so a query on it misses.
    send_request(FUNC_CLEAR, value_t'(0));
    send_request(FUNC_QUERY, value_t'(7));
    // A list loaded out of order.
    send_request(FUNC_APPEND, value_t'(5));
    send_request(FUNC_APPEND, value_t'(1));
    send_request(FUNC_APPEND, value_t'(3));
    send_request(FUNC_QUERY, value_t'(1));
    send_request(FUNC_QUERY, value_t'(3));
    send_request(FUNC_QUERY, value_t'(5));
    drain_pause();

    // Random part: mostly well-formed load-and-query sequences. Once, the
    // list is filled past capacity so overflow and the top indices appear.
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (!full_done && sent_items >= 300) begin
        send_request(FUNC_CLEAR, value_t'($urandom()));
        append_sorted(LIST_DEPTH + 3, -64'sd2147483648 + $urandom_range(0, 5), 3);
        run_queries(40);
        full_done = 1'b1;
      end else if ($urandom_range(0, 99) < 75) begin
        sorted_segment();
      end else begin
        noise_segment();
      end
      if ($urandom_range(0, 5) == 0) drain_pause();
    end

    s_tvalid <= 1'b0;
    while (board.answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.answers.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
